>>> src/tspsg_pkg.sv
`default_nettype none

package tspsg_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam int START_W = 9;

    localparam logic [POS_W-1:0] POS_ADAPT_CTRL = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ADAPT_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

    localparam logic [START_W-1:0] PAYLOAD_DEFAULT = START_W'(4);
    localparam logic [START_W-1:0] ADAPT_OFFSET = START_W'(5);
    localparam logic [1:0] ADAPT_BOTH = 2'd3;
    localparam logic [7:0] MAX_ADAPT_LEN = 8'd178;

    localparam logic [7:0] START_BYTE0 = 8'h00;
    localparam logic [7:0] START_BYTE1 = 8'h00;
    localparam logic [7:0] START_BYTE2 = 8'h01;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_LOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_HIGH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_LOW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_HIGH = 8'd3;

    localparam logic [7:0] VIDEO_LOW_RST = 8'hE0;
    localparam logic [7:0] VIDEO_HIGH_RST = 8'hEF;
    localparam logic [7:0] AUDIO_LOW_RST = 8'hC0;
    localparam logic [7:0] AUDIO_HIGH_RST = 8'hDF;

endpackage

`default_nettype wire

>>> src/ts_pes_start_gate.sv
// Latency: a byte leaves one packet later. It is read on the beat that writes the same packet
//   position and then passes through the output register.
// Throughput: one input beat per cycle while in_stall is low; a single-port packet store, read before write.
// A two-entry output stage (register and skid) stalls input only when both are full.
// Reset clears position, gate and start-code state and reloads the id ranges;
// store contents stay undefined and are never read before being written.
`default_nettype none

module ts_pes_start_gate
    import tspsg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           stream_byte,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic                      packet_first,
    output logic                      packet_last
);

    logic [7:0] video_low_reg, video_high_reg, audio_low_reg, audio_high_reg;

    logic [7:0] store_mem [PACKET_BYTES];

    logic [POS_W-1:0]   byte_position_reg, byte_position_next;
    logic [1:0]         adapt_control_reg, adapt_control_next;
    logic [START_W-1:0] payload_start_reg, payload_start_next;
    logic               start_code_ok_reg, start_code_ok_next;
    logic               previous_passes_reg, previous_passes_next;
    logic               gate_open_reg, gate_open_next;

    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [7:0] out_byte_reg, skid_byte_reg;
    logic       out_first_reg, out_last_reg, skid_first_reg, skid_last_reg;

    logic accept, push, pop, load_out, load_skid;
    logic pos_first, pos_last, id_ok, passes;
    logic [START_W:0] pos_ext, ps_ext;

    assign in_stall = skid_valid_reg;
    assign accept = in_valid && !skid_valid_reg;
    assign push = accept && previous_passes_reg;
    assign pop = out_valid_reg && !out_stall;
    assign load_out = skid_valid_reg ? pop : (push && (!out_valid_reg || pop));
    assign load_skid = !skid_valid_reg && push && out_valid_reg && !pop;

    assign pos_first = (byte_position_reg == '0);
    assign pos_last = (byte_position_reg == POS_LAST);
    assign pos_ext = (START_W+1)'(byte_position_reg);
    assign ps_ext = {1'b0, payload_start_reg};

    assign id_ok = (stream_byte >= video_low_reg && stream_byte <= video_high_reg)
                || (stream_byte >= audio_low_reg && stream_byte <= audio_high_reg);

    always_comb
    begin
        adapt_control_next = adapt_control_reg;
        payload_start_next = payload_start_reg;
        start_code_ok_next = start_code_ok_reg;
        byte_position_next = byte_position_reg;
        previous_passes_next = previous_passes_reg;
        gate_open_next = gate_open_reg;
        passes = 1'b0;
        if (accept)
        begin
            if (byte_position_reg == POS_ADAPT_CTRL)
            begin
                adapt_control_next = stream_byte[5:4];
                payload_start_next = PAYLOAD_DEFAULT;
                start_code_ok_next = 1'b1;
            end
            else if (byte_position_reg == POS_ADAPT_LEN && adapt_control_reg == ADAPT_BOTH)
            begin
                start_code_ok_next = start_code_ok_reg && (stream_byte <= MAX_ADAPT_LEN);
                payload_start_next = ADAPT_OFFSET + START_W'(stream_byte);
            end
            else if (byte_position_reg >= POS_ADAPT_LEN)
            begin
                priority if (pos_ext == ps_ext)
                    start_code_ok_next = start_code_ok_reg && (stream_byte == START_BYTE0);
                else if (pos_ext == ps_ext + (START_W+1)'(1))
                    start_code_ok_next = start_code_ok_reg && (stream_byte == START_BYTE1);
                else if (pos_ext == ps_ext + (START_W+1)'(2))
                    start_code_ok_next = start_code_ok_reg && (stream_byte == START_BYTE2);
                else if (pos_ext == ps_ext + (START_W+1)'(3))
                    start_code_ok_next = start_code_ok_reg && id_ok;
                else
                    start_code_ok_next = start_code_ok_reg;
            end

            if (pos_last)
            begin
                passes = gate_open_reg || (start_code_ok_next
                         && (ps_ext + (START_W+1)'(3) < (START_W+1)'(PACKET_BYTES)));
                gate_open_next = gate_open_reg || passes;
                previous_passes_next = passes;
                start_code_ok_next = 1'b0;
                byte_position_next = '0;
            end
            else
            begin
                byte_position_next = byte_position_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        if (skid_valid_reg)
        begin
            out_valid_next = 1'b1;
            skid_valid_next = !pop;
        end
        else
        begin
            out_valid_next = push || (out_valid_reg && !pop);
            skid_valid_next = load_skid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_low_reg <= VIDEO_LOW_RST;
            video_high_reg <= VIDEO_HIGH_RST;
            audio_low_reg <= AUDIO_LOW_RST;
            audio_high_reg <= AUDIO_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VIDEO_LOW:  video_low_reg <= cfg_data;
                REG_VIDEO_HIGH: video_high_reg <= cfg_data;
                REG_AUDIO_LOW:  audio_low_reg <= cfg_data;
                REG_AUDIO_HIGH: audio_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            adapt_control_reg <= '0;
            payload_start_reg <= PAYLOAD_DEFAULT;
            start_code_ok_reg <= 1'b0;
            previous_passes_reg <= 1'b0;
            gate_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            adapt_control_reg <= adapt_control_next;
            payload_start_reg <= payload_start_next;
            start_code_ok_reg <= start_code_ok_next;
            previous_passes_reg <= previous_passes_next;
            gate_open_reg <= gate_open_next;
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // packet store: read-first single port
    always_ff @(posedge clk)
    begin
        if (accept)
            store_mem[byte_position_reg] <= stream_byte;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_byte_reg <= skid_byte_reg;
                out_first_reg <= skid_first_reg;
                out_last_reg <= skid_last_reg;
            end
            else
            begin
                out_byte_reg <= store_mem[byte_position_reg];
                out_first_reg <= pos_first;
                out_last_reg <= pos_last;
            end
        end
        if (load_skid)
        begin
            skid_byte_reg <= store_mem[byte_position_reg];
            skid_first_reg <= pos_first;
            skid_last_reg <= pos_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign packet_first = out_first_reg;
    assign packet_last = out_last_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held without an output beat");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= POS_LAST)
        else $error("byte position beyond packet");

    a_gate_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        gate_open_reg |=> gate_open_reg)
        else $error("gate closed after opening");

    a_pass_needs_gate: assert property (@(posedge clk) disable iff (!rst_n)
        previous_passes_reg |-> gate_open_reg)
        else $error("packet passing with gate closed");

    a_emit_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !previous_passes_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("beat emitted for a held packet");

endmodule

`default_nettype wire
